// ----- hw/rtl/vfat_pkg.sv -----
package vfat_pkg;

   localparam int MAX_VERTICES     = 4096;
   localparam int SLOTS_PER_VERTEX = 20;
   localparam int MAX_FACES        = 8192;

   localparam int REQ_W   = 2;
   localparam int VERT_W  = 12;
   localparam int SLOT_W  = 5;
   localparam int CNT_W   = 5;
   localparam int FACE_W  = 13;
   localparam int NFACE_W = 14;

   localparam int VIDX_W    = $clog2(MAX_VERTICES);
   localparam int TBL_DEPTH = MAX_VERTICES * SLOTS_PER_VERTEX;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [REQ_W-1:0] {
      REQ_ADD   = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NOP   = 2'd3
   } req_kind_type;

   // which earlier corner a corner repeats
   typedef enum logic [1:0] {
      DUP_NONE = 2'd0,
      DUP_A    = 2'd1,
      DUP_B    = 2'd2
   } dup_type;

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_CLEAR,
      BK_ADD,
      BK_READ,
      BK_READW,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      req_kind_type              kind;
      logic [2:0][VERT_W-1:0]    vert;
      logic [2:0]                act;
      dup_type                   dup_b;
      dup_type                   dup_c;
      logic [VERT_W-1:0]         qv;
      logic [SLOT_W-1:0]         qs;
      logic                      qok;
   } work_type;

   typedef struct packed {
      logic [FACE_W-1:0]         face_id;
      logic [2:0][SLOT_W-1:0]    slot;
      logic [2:0]                full;
      logic                      faces_full;
      logic [FACE_W-1:0]         read_face;
      logic                      read_valid;
      logic [CNT_W-1:0]          read_count;
   } res_type;

   function automatic logic in_range(input logic [VERT_W-1:0] v);
      return ({1'b0, v} < (VERT_W+1)'(MAX_VERTICES));
   endfunction

   function automatic logic [TBL_AW-1:0] tbl_addr(input logic [VIDX_W-1:0] v,
                                                  input logic [SLOT_W-1:0] s);
      return TBL_AW'(v) * TBL_AW'(SLOTS_PER_VERTEX) + TBL_AW'(s);
   endfunction

endpackage

// ----- hw/rtl/vertex_face_adjacency_table.sv -----
// Vertex to face adjacency table.
// Request channel (req_*, valid/ready): req_type selects add triangle, read
// one bucket slot, clear the table, or no operation. Every accepted word
// returns exactly one response word on the rsp_* channel, in request order.
// A front register classifies each word (repeated corners, index range) and
// hands it through a two-word queue to the back sequencer, which owns the
// bucket count memory and the slot memory (one read and one write port each).
// Back-end work per word: an add does one count read-modify-write per
// distinct in-range corner, overlapped; a clear sweeps the count memory
// one entry a cycle.
// After reset the count memory is swept to zero, all MAX_VERTICES (4096)
// entries; req_ready stays low until the sweep is done.
// A stalled receiver holds the response in the output register; the back
// end waits for it to drain while the front and queue keep taking up to
// three more request words.
module vertex_face_adjacency_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [vfat_pkg::REQ_W-1:0]  req_type,
   input  logic [vfat_pkg::VERT_W-1:0] req_vert_a,
   input  logic [vfat_pkg::VERT_W-1:0] req_vert_b,
   input  logic [vfat_pkg::VERT_W-1:0] req_vert_c,
   input  logic [vfat_pkg::VERT_W-1:0] req_query_vertex,
   input  logic [vfat_pkg::SLOT_W-1:0] req_query_slot,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [vfat_pkg::FACE_W-1:0] rsp_face_id,
   output logic [vfat_pkg::SLOT_W-1:0] rsp_slot_a,
   output logic [vfat_pkg::SLOT_W-1:0] rsp_slot_b,
   output logic [vfat_pkg::SLOT_W-1:0] rsp_slot_c,
   output logic                        rsp_full_a,
   output logic                        rsp_full_b,
   output logic                        rsp_full_c,
   output logic                        rsp_faces_full,
   output logic [vfat_pkg::FACE_W-1:0] rsp_read_face,
   output logic                        rsp_read_valid,
   output logic [vfat_pkg::CNT_W-1:0]  rsp_read_count
);

   logic               init_busy;
   logic               push_valid, push_ready;
   vfat_pkg::work_type push_word;
   logic               pop_valid, pop_ready;
   vfat_pkg::work_type pop_word;
   vfat_pkg::res_type  rsp_word;

   vfat_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_vert_a       (req_vert_a),
      .req_vert_b       (req_vert_b),
      .req_vert_c       (req_vert_c),
      .req_query_vertex (req_query_vertex),
      .req_query_slot   (req_query_slot),
      .init_busy        (init_busy),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_word        (push_word)
   );

   vfat_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   vfat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_word  (pop_word),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_face_id    = rsp_word.face_id;
   assign rsp_slot_a     = rsp_word.slot[0];
   assign rsp_slot_b     = rsp_word.slot[1];
   assign rsp_slot_c     = rsp_word.slot[2];
   assign rsp_full_a     = rsp_word.full[0];
   assign rsp_full_b     = rsp_word.full[1];
   assign rsp_full_c     = rsp_word.full[2];
   assign rsp_faces_full = rsp_word.faces_full;
   assign rsp_read_face  = rsp_word.read_face;
   assign rsp_read_valid = rsp_word.read_valid;
   assign rsp_read_count = rsp_word.read_count;

   // an overflowed bucket always reports its last slot
   a_full_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_a
         |-> rsp_slot_a == vfat_pkg::SLOT_W'(vfat_pkg::SLOTS_PER_VERTEX - 1))
      else $error("full bucket reported a slot other than the last");

   // a hit can only come from an occupied bucket
   a_hit_has_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid
         |-> rsp_read_count != '0 &&
             rsp_read_count <= vfat_pkg::CNT_W'(vfat_pkg::SLOTS_PER_VERTEX))
      else $error("read hit with an impossible bucket count");

   // a refused add leaves every other field clear
   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_faces_full
         |-> rsp_face_id == '0 && !rsp_full_a && !rsp_full_b && !rsp_full_c &&
             rsp_slot_a == '0 && rsp_slot_b == '0 && rsp_slot_c == '0)
      else $error("refused add carries face data");

endmodule

// ----- hw/rtl/vfat_front.sv -----
module vfat_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [vfat_pkg::REQ_W-1:0]  req_type,
   input  logic [vfat_pkg::VERT_W-1:0] req_vert_a,
   input  logic [vfat_pkg::VERT_W-1:0] req_vert_b,
   input  logic [vfat_pkg::VERT_W-1:0] req_vert_c,
   input  logic [vfat_pkg::VERT_W-1:0] req_query_vertex,
   input  logic [vfat_pkg::SLOT_W-1:0] req_query_slot,
   input  logic                       init_busy,
   output logic                       push_valid,
   input  logic                       push_ready,
   output vfat_pkg::work_type         push_word
);

   logic               vld_ff, vld_in;
   vfat_pkg::work_type word_ff, word_in;
   vfat_pkg::work_type cls;
   logic               accept;

   // classify: duplicate corners and out-of-range indices
   always_comb begin
      cls       = '0;
      cls.kind  = vfat_pkg::req_kind_type'(req_type);
      cls.vert[0] = req_vert_a;
      cls.vert[1] = req_vert_b;
      cls.vert[2] = req_vert_c;
      cls.dup_b = (req_vert_b == req_vert_a) ? vfat_pkg::DUP_A : vfat_pkg::DUP_NONE;
      if (req_vert_c == req_vert_a) begin
         cls.dup_c = vfat_pkg::DUP_A;
      end else if (req_vert_c == req_vert_b) begin
         cls.dup_c = vfat_pkg::DUP_B;
      end else begin
         cls.dup_c = vfat_pkg::DUP_NONE;
      end
      cls.act[0] = vfat_pkg::in_range(req_vert_a);
      cls.act[1] = vfat_pkg::in_range(req_vert_b) && (cls.dup_b == vfat_pkg::DUP_NONE);
      cls.act[2] = vfat_pkg::in_range(req_vert_c) && (cls.dup_c == vfat_pkg::DUP_NONE);
      cls.qv  = req_query_vertex;
      cls.qs  = req_query_slot;
      cls.qok = vfat_pkg::in_range(req_query_vertex);
   end

   assign req_ready  = !init_busy && (!vld_ff || push_ready);
   assign accept     = req_valid && req_ready;
   assign push_valid = vld_ff;
   assign push_word  = word_ff;

   always_comb begin
      vld_in  = vld_ff && !push_ready;
      word_in = word_ff;
      if (accept) begin
         vld_in  = 1'b1;
         word_in = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      word_ff <= word_in;
   end

endmodule

// ----- hw/rtl/vfat_queue.sv -----
module vfat_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  vfat_pkg::work_type push_word,
   output logic               pop_valid,
   input  logic               pop_ready,
   output vfat_pkg::work_type pop_word
);

   vfat_pkg::work_type                q_ff [vfat_pkg::QUEUE_DEPTH];
   logic [vfat_pkg::QPTR_W-1:0]       wptr_ff, wptr_in;
   logic [vfat_pkg::QPTR_W-1:0]       rptr_ff, rptr_in;
   logic [vfat_pkg::QFILL_W-1:0]      fill_ff, fill_in;
   logic                              do_push, do_pop;

   assign push_ready = (fill_ff != vfat_pkg::QFILL_W'(vfat_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_word   = q_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == vfat_pkg::QPTR_W'(vfat_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == vfat_pkg::QPTR_W'(vfat_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         q_ff[wptr_ff] <= push_word;
      end
   end

endmodule

// ----- hw/rtl/vfat_back.sv -----
module vfat_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  vfat_pkg::work_type pop_word,
   output logic               init_busy,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output vfat_pkg::res_type  rsp_word
);

   vfat_pkg::back_state_type          state_ff, state_in;
   logic [vfat_pkg::VIDX_W-1:0]       sweep_ff, sweep_in;
   logic [1:0]                        corner_ff, corner_in;
   vfat_pkg::work_type                cur_ff, cur_in;
   logic [vfat_pkg::NFACE_W-1:0]      nface_ff, nface_in;
   logic [vfat_pkg::FACE_W-1:0]       face_ff, face_in;
   vfat_pkg::res_type                 res_ff, res_in;
   logic                              rsp_vld_ff, rsp_vld_in;
   vfat_pkg::res_type                 rsp_ff, rsp_in;

   logic [vfat_pkg::CNT_W-1:0]        cnt_mem [vfat_pkg::MAX_VERTICES];
   logic [vfat_pkg::FACE_W-1:0]       slot_mem [vfat_pkg::TBL_DEPTH];
   logic [vfat_pkg::CNT_W-1:0]        cnt_rd_ff;
   logic [vfat_pkg::FACE_W-1:0]       slot_rd_ff;

   logic                              cnt_we;
   logic [vfat_pkg::VIDX_W-1:0]       cnt_waddr, cnt_raddr;
   logic [vfat_pkg::CNT_W-1:0]        cnt_wdata;
   logic                              slot_we;
   logic [vfat_pkg::TBL_AW-1:0]       slot_waddr, slot_raddr;

   logic                              sweep_last;
   logic                              face_cap;
   logic                              out_free;
   logic [1:0]                        wc;
   logic                              bkt_full;
   logic [vfat_pkg::SLOT_W-1:0]       pos;
   logic [vfat_pkg::SLOT_W-1:0]       qs_addr;
   vfat_pkg::res_type                 fixed;

   assign sweep_last = (sweep_ff == vfat_pkg::VIDX_W'(vfat_pkg::MAX_VERTICES - 1));
   assign face_cap   = (nface_ff >= vfat_pkg::NFACE_W'(vfat_pkg::MAX_FACES));
   assign out_free   = !rsp_vld_ff || rsp_ready;
   assign init_busy  = (state_ff == vfat_pkg::BK_INIT);
   assign rsp_valid  = rsp_vld_ff;
   assign rsp_word   = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vfat_pkg::BK_INIT: begin
            if (sweep_last) state_in = vfat_pkg::BK_IDLE;
         end
         vfat_pkg::BK_IDLE: begin
            if (pop_valid) begin
               case (pop_word.kind)
                  vfat_pkg::REQ_ADD:   state_in = face_cap ? vfat_pkg::BK_DONE
                                                           : vfat_pkg::BK_ADD;
                  vfat_pkg::REQ_READ:  state_in = vfat_pkg::BK_READ;
                  vfat_pkg::REQ_CLEAR: state_in = vfat_pkg::BK_CLEAR;
                  default:             state_in = vfat_pkg::BK_DONE;
               endcase
            end
         end
         vfat_pkg::BK_CLEAR: begin
            if (sweep_last) state_in = vfat_pkg::BK_DONE;
         end
         vfat_pkg::BK_ADD: begin
            if (corner_ff == 2'd3) state_in = vfat_pkg::BK_DONE;
         end
         vfat_pkg::BK_READ:  state_in = vfat_pkg::BK_READW;
         vfat_pkg::BK_READW: state_in = vfat_pkg::BK_DONE;
         vfat_pkg::BK_DONE: begin
            if (out_free) state_in = vfat_pkg::BK_IDLE;
         end
         default: state_in = vfat_pkg::BK_IDLE;
      endcase
   end

   // repeated corners report the slot of the first occurrence
   always_comb begin
      fixed = res_ff;
      case (cur_ff.dup_b)
         vfat_pkg::DUP_A: begin
            fixed.slot[1] = res_ff.slot[0];
            fixed.full[1] = res_ff.full[0];
         end
         default: ;
      endcase
      case (cur_ff.dup_c)
         vfat_pkg::DUP_A: begin
            fixed.slot[2] = res_ff.slot[0];
            fixed.full[2] = res_ff.full[0];
         end
         vfat_pkg::DUP_B: begin
            fixed.slot[2] = fixed.slot[1];
            fixed.full[2] = fixed.full[1];
         end
         default: ;
      endcase
   end

   // datapath and memory control
   always_comb begin
      sweep_in   = sweep_ff;
      corner_in  = corner_ff;
      cur_in     = cur_ff;
      nface_in   = nface_ff;
      face_in    = face_ff;
      res_in     = res_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ready;
      rsp_in     = rsp_ff;
      pop_ready  = 1'b0;
      cnt_we     = 1'b0;
      cnt_waddr  = '0;
      cnt_wdata  = '0;
      cnt_raddr  = '0;
      slot_we    = 1'b0;
      slot_waddr = '0;
      slot_raddr = '0;
      wc         = corner_ff - 2'd1;
      bkt_full   = (cnt_rd_ff >= vfat_pkg::CNT_W'(vfat_pkg::SLOTS_PER_VERTEX));
      pos        = bkt_full ? vfat_pkg::SLOT_W'(vfat_pkg::SLOTS_PER_VERTEX - 1) : cnt_rd_ff;
      qs_addr    = (cur_ff.qs < vfat_pkg::SLOT_W'(vfat_pkg::SLOTS_PER_VERTEX)) ? cur_ff.qs
                                                                             : '0;
      case (state_ff)
         vfat_pkg::BK_INIT, vfat_pkg::BK_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = sweep_ff;
            sweep_in  = sweep_last ? '0 : sweep_ff + 1'b1;
         end
         vfat_pkg::BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cur_in    = pop_word;
               res_in    = '0;
               corner_in = '0;
               sweep_in  = '0;
               if (pop_word.kind == vfat_pkg::REQ_ADD) begin
                  if (face_cap) begin
                     res_in.faces_full = 1'b1;
                  end else begin
                     face_in        = nface_ff[vfat_pkg::FACE_W-1:0];
                     res_in.face_id = nface_ff[vfat_pkg::FACE_W-1:0];
                     nface_in       = nface_ff + 1'b1;
                  end
               end
               if (pop_word.kind == vfat_pkg::REQ_CLEAR) begin
                  nface_in = '0;
               end
            end
         end
         vfat_pkg::BK_ADD: begin
            // read count of corner k while updating corner k-1
            if (corner_ff != 2'd3) begin
               cnt_raddr = cur_ff.vert[corner_ff][vfat_pkg::VIDX_W-1:0];
            end
            if (corner_ff != 2'd0 && cur_ff.act[wc]) begin
               cnt_we      = !bkt_full;
               cnt_waddr   = cur_ff.vert[wc][vfat_pkg::VIDX_W-1:0];
               cnt_wdata   = cnt_rd_ff + 1'b1;
               slot_we     = 1'b1;
               slot_waddr  = vfat_pkg::tbl_addr(cur_ff.vert[wc][vfat_pkg::VIDX_W-1:0], pos);
               res_in.slot[wc] = pos;
               res_in.full[wc] = bkt_full;
            end
            corner_in = corner_ff + 2'd1;
         end
         vfat_pkg::BK_READ: begin
            cnt_raddr  = cur_ff.qv[vfat_pkg::VIDX_W-1:0];
            slot_raddr = vfat_pkg::tbl_addr(cur_ff.qv[vfat_pkg::VIDX_W-1:0], qs_addr);
         end
         vfat_pkg::BK_READW: begin
            if (cur_ff.qok) begin
               res_in.read_count = cnt_rd_ff;
               if (cur_ff.qs < cnt_rd_ff) begin
                  res_in.read_valid = 1'b1;
                  res_in.read_face  = slot_rd_ff;
               end
            end
         end
         vfat_pkg::BK_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_in     = fixed;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= vfat_pkg::BK_INIT;
         sweep_ff   <= '0;
         corner_ff  <= '0;
         nface_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sweep_ff   <= sweep_in;
         corner_ff  <= corner_in;
         nface_ff   <= nface_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      cur_ff  <= cur_in;
      face_ff <= face_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= face_ff;
      end
      slot_rd_ff <= slot_mem[slot_raddr];
   end

endmodule
